### src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types, operation codes and defaults shared by the frame allocator files.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int STORE_FRAMES_DEF  = 4096;
    localparam int REFCOUNT_BITS_DEF = 16;

    localparam logic [12:0] CNT_MAX = 13'h1FFF;

    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_FREE    = 3'd1;
    localparam logic [2:0] OP_REF_INC = 3'd2;
    localparam logic [2:0] OP_REF_DEC = 3'd3;
    localparam logic [2:0] OP_REF_GET = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;
    localparam logic [2:0] OP_RESERVE = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] frame_index;
        logic [12:0] frame_count;
    } in_item_t;

    typedef struct packed {
        logic [11:0] result_frame;
        logic [15:0] ref_value;
        logic [1:0]  status;
        logic [12:0] used_total;
    } out_item_t;

endpackage

### src/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/bfa_word_unit.sv
// ----------------------------------------------------------------------------
// bfa_word_unit
// Bitmap word unit: finds the lowest clear bit of a word and counts the
// clear bits that fall under a mask.
// ----------------------------------------------------------------------------
module bfa_word_unit (
    input  logic [31:0] word,
    input  logic [31:0] mask,
    output logic        zero_found,
    output logic [4:0]  zero_idx,
    output logic [5:0]  new_cnt
);

    logic [31:0] fresh;

    assign zero_found = (word != 32'hFFFF_FFFF);
    assign fresh      = mask & ~word;

    // Walking down from the top leaves the lowest clear bit selected.
    always_comb
    begin
        zero_idx = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!word[i])
            begin
                zero_idx = 5'(i);
            end
        end
    end

    always_comb
    begin
        new_cnt = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            new_cnt = new_cnt + 6'(fresh[i]);
        end
    end

endmodule

### src/bitmap_frame_allocator_refcount.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_refcount
// First-fit bitmap frame allocator with per-frame reference counts.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that sets every bitmap word and
// zeroes every reference count; it takes no item until that pass ends. Each
// transfer is then handled alone, through the lookup and execute states: free,
// ref_inc, ref_dec, ref_get, the unused code and an empty range then offer
// their result. Alloc then scans bitmap words, up to managed_frames/32 words
// (at most STORE_FRAMES/32), and offers its result when it finds a clear bit
// or the words run out. Release and reserve walk every bitmap word the range
// touches before offering theirs. The next input transfer can be taken in the
// cycle after the output transfer. The bitmap RAM's single read
// port, streaming one 32-frame word per cycle into the shared word unit, sets
// the length of scans and ranges.
module bitmap_frame_allocator_refcount #(
    parameter int STORE_FRAMES  = bfa_pkg::STORE_FRAMES_DEF,
    parameter int REFCOUNT_BITS = bfa_pkg::REFCOUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bfa_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output bfa_pkg::out_item_t out_data,
    input  logic              cfg_wr_en,
    input  logic [12:0]       cfg_wr_data
);

    localparam int WORDS = STORE_FRAMES / 32;
    localparam int FAW   = $clog2(STORE_FRAMES);
    localparam int WAW   = $clog2(WORDS);
    localparam int PW    = ((FAW > 13) ? FAW : 13) + 1;
    localparam int WPW   = PW - 5;
    localparam logic [REFCOUNT_BITS-1:0] REF_MAX = '1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_LOOKUP = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_RANGE  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [FAW-1:0] clr_reg, clr_next;
    logic [PW-1:0]  managed_reg, managed_next;
    logic [2:0]     op_reg, op_next;
    logic [11:0]    f_reg, f_next;
    logic [12:0]    n_reg, n_next;
    logic [WPW-1:0] scan_reg, scan_next;
    logic [WPW-1:0] chk_reg, chk_next;
    logic [WPW-1:0] lim_reg, lim_next;
    logic           pend_reg, pend_next;
    logic [PW-1:0]  end_reg, end_next;
    logic [11:0]    res_frame_reg, res_frame_next;
    logic [15:0]    ref_out_reg, ref_out_next;
    logic [1:0]     status_reg, status_next;
    logic [12:0]    used_cnt_reg, used_cnt_next;

    logic                     bm_we;
    logic [WAW-1:0]           bm_waddr, bm_raddr;
    logic [31:0]              bm_wdata, bm_rdata;
    logic                     ref_we;
    logic [FAW-1:0]           ref_waddr;
    logic [REFCOUNT_BITS-1:0] ref_wdata, ref_rdata;

    logic [31:0]    unit_mask;
    logic           zero_found;
    logic [4:0]     zero_idx;
    logic [5:0]     new_cnt;

    logic [PW-1:0]  f_ext, range_end, base, e_lim;
    logic           in_store, free_ok, bit_now;
    logic [4:0]     s_rel;
    logic [5:0]     e_rel;
    logic [31:0]    range_mask, bit_mask;
    logic [REFCOUNT_BITS-1:0] ref_new;
    logic [FAW-1:0] alloc_frame;
    logic [13:0]    cnt_sum;

    assign f_ext     = PW'(f_reg);
    assign in_store  = f_ext < PW'(STORE_FRAMES);
    assign free_ok   = in_store && (f_ext < managed_reg);
    assign bit_now   = bm_rdata[f_reg[4:0]];
    assign bit_mask  = 32'd1 << f_reg[4:0];
    assign range_end = ((f_ext + PW'(n_reg)) > PW'(STORE_FRAMES))
                       ? PW'(STORE_FRAMES) : (f_ext + PW'(n_reg));

    // Mask of the range's frames inside the word being processed.
    assign base       = {chk_reg, 5'd0};
    assign e_lim      = base + PW'(32);
    assign s_rel      = (f_ext > base) ? 5'(f_ext - base) : 5'd0;
    assign e_rel      = (end_reg >= e_lim) ? 6'd32 : 6'(end_reg - base);
    assign range_mask = (32'hFFFF_FFFF << s_rel) & (32'hFFFF_FFFF >> (6'd32 - e_rel));
    assign unit_mask  = range_mask;

    assign alloc_frame = {chk_reg[WAW-1:0], zero_idx};
    assign cnt_sum     = 14'(used_cnt_reg) + 14'(new_cnt);

    assign bm_raddr = (state_reg == S_LOOKUP) ? f_ext[FAW-1:5] : scan_reg[WAW-1:0];

    bfa_ram #(
        .WIDTH(32),
        .DEPTH(WORDS)
    ) u_bitmap (
        .clk  (clk),
        .we   (bm_we),
        .waddr(bm_waddr),
        .wdata(bm_wdata),
        .raddr(bm_raddr),
        .rdata(bm_rdata)
    );

    bfa_ram #(
        .WIDTH(REFCOUNT_BITS),
        .DEPTH(STORE_FRAMES)
    ) u_refcnt (
        .clk  (clk),
        .we   (ref_we),
        .waddr(ref_waddr),
        .wdata(ref_wdata),
        .raddr(f_ext[FAW-1:0]),
        .rdata(ref_rdata)
    );

    bfa_word_unit u_word (
        .word      (bm_rdata),
        .mask      (unit_mask),
        .zero_found(zero_found),
        .zero_idx  (zero_idx),
        .new_cnt   (new_cnt)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        managed_next   = cfg_wr_en ? PW'(cfg_wr_data) : managed_reg;
        op_next        = op_reg;
        f_next         = f_reg;
        n_next         = n_reg;
        scan_next      = scan_reg;
        chk_next       = chk_reg;
        lim_next       = lim_reg;
        pend_next      = pend_reg;
        end_next       = end_reg;
        res_frame_next = res_frame_reg;
        ref_out_next   = ref_out_reg;
        status_next    = status_reg;
        used_cnt_next  = used_cnt_reg;
        bm_we          = 1'b0;
        bm_waddr       = f_ext[FAW-1:5];
        bm_wdata       = bm_rdata & ~bit_mask;
        ref_we         = 1'b0;
        ref_waddr      = f_ext[FAW-1:0];
        ref_wdata      = '0;
        ref_new        = ref_rdata;

        unique case (state_reg)
            S_CLEAR:
            begin
                ref_we    = 1'b1;
                ref_waddr = clr_reg;
                bm_we     = clr_reg < FAW'(WORDS);
                bm_waddr  = clr_reg[WAW-1:0];
                bm_wdata  = 32'hFFFF_FFFF;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == FAW'(STORE_FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.opcode;
                    f_next     = in_data.frame_index;
                    n_next     = in_data.frame_count;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_frame_next = f_reg;
                status_next    = bfa_pkg::ST_OK;
                ref_out_next   = in_store ? 16'(ref_rdata) : 16'd0;
                state_next     = S_OUT;
                pend_next      = 1'b0;
                unique case (op_reg)
                    bfa_pkg::OP_ALLOC:
                    begin
                        scan_next  = '0;
                        lim_next   = (managed_reg[PW-1:5] > WPW'(WORDS))
                                     ? WPW'(WORDS) : managed_reg[PW-1:5];
                        state_next = S_SCAN;
                    end
                    bfa_pkg::OP_FREE,
                    bfa_pkg::OP_REF_INC,
                    bfa_pkg::OP_REF_DEC,
                    bfa_pkg::OP_REF_GET:
                    begin
                        if (!in_store)
                        begin
                            status_next = bfa_pkg::ST_INVALID;
                        end
                        else
                        begin
                            if (op_reg == bfa_pkg::OP_REF_INC)
                            begin
                                ref_new = (ref_rdata != REF_MAX) ? ref_rdata + 1'b1 : ref_rdata;
                            end
                            else if (op_reg == bfa_pkg::OP_REF_DEC)
                            begin
                                ref_new = (ref_rdata != '0) ? ref_rdata - 1'b1 : ref_rdata;
                            end
                            ref_we       = (op_reg == bfa_pkg::OP_REF_INC)
                                           || (op_reg == bfa_pkg::OP_REF_DEC);
                            ref_wdata    = ref_new;
                            ref_out_next = 16'(ref_new);
                            // A free, or a decrement that reaches zero, frees the frame.
                            if ((op_reg == bfa_pkg::OP_FREE)
                                || ((op_reg == bfa_pkg::OP_REF_DEC) && (ref_new == '0)))
                            begin
                                if (!free_ok)
                                begin
                                    status_next = bfa_pkg::ST_INVALID;
                                end
                                else if (!bit_now)
                                begin
                                    status_next = bfa_pkg::ST_DOUBLE;
                                end
                                else
                                begin
                                    bm_we = 1'b1;
                                    if (used_cnt_reg != 13'd0)
                                    begin
                                        used_cnt_next = used_cnt_reg - 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    bfa_pkg::OP_RELEASE,
                    bfa_pkg::OP_RESERVE:
                    begin
                        if (f_ext < range_end)
                        begin
                            scan_next  = f_ext[PW-1:5];
                            lim_next   = WPW'((range_end - 1'b1) >> 5) + 1'b1;
                            end_next   = range_end;
                            state_next = S_RANGE;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (pend_reg && zero_found)
                begin
                    bm_we          = 1'b1;
                    bm_waddr       = chk_reg[WAW-1:0];
                    bm_wdata       = bm_rdata | (32'd1 << zero_idx);
                    ref_we         = 1'b1;
                    ref_waddr      = alloc_frame;
                    ref_wdata      = REFCOUNT_BITS'(1);
                    res_frame_next = 12'(alloc_frame);
                    ref_out_next   = 16'd1;
                    if (used_cnt_reg != bfa_pkg::CNT_MAX)
                    begin
                        used_cnt_next = used_cnt_reg + 1'b1;
                    end
                    pend_next  = 1'b0;
                    state_next = S_OUT;
                end
                else if (scan_reg < lim_reg)
                begin
                    chk_next  = scan_reg;
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    res_frame_next = 12'd0;
                    ref_out_next   = 16'd0;
                    status_next    = bfa_pkg::ST_NOMEM;
                    pend_next      = 1'b0;
                    state_next     = S_OUT;
                end
            end
            S_RANGE:
            begin
                if (pend_reg)
                begin
                    bm_we    = 1'b1;
                    bm_waddr = chk_reg[WAW-1:0];
                    if (op_reg == bfa_pkg::OP_RELEASE)
                    begin
                        bm_wdata = bm_rdata & ~range_mask;
                    end
                    else
                    begin
                        bm_wdata      = bm_rdata | range_mask;
                        used_cnt_next = (cnt_sum > 14'(bfa_pkg::CNT_MAX))
                                        ? bfa_pkg::CNT_MAX : 13'(cnt_sum);
                    end
                end
                if (scan_reg < lim_reg)
                begin
                    chk_next  = scan_reg;
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            managed_reg  <= PW'(STORE_FRAMES);
            pend_reg     <= 1'b0;
            used_cnt_reg <= 13'd0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            managed_reg  <= managed_next;
            pend_reg     <= pend_next;
            used_cnt_reg <= used_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        f_reg         <= f_next;
        n_reg         <= n_next;
        scan_reg      <= scan_next;
        chk_reg       <= chk_next;
        lim_reg       <= lim_next;
        end_reg       <= end_next;
        res_frame_reg <= res_frame_next;
        ref_out_reg   <= ref_out_next;
        status_reg    <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    assign out_data.result_frame = res_frame_reg;
    assign out_data.ref_value    = ref_out_reg;
    assign out_data.status       = status_reg;
    assign out_data.used_total   = used_cnt_reg;

    // A completed output transfer always returns the sequencer to idle.
    a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after output transfer");

    // A pending bitmap read exists only while a scan or a range walk runs.
    a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SCAN) || (state_reg == S_RANGE))
        else $error("pending bitmap word outside scan or range");

    // The used counter only moves while an operation is executing.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> $stable(used_cnt_reg))
        else $error("used counter changed while idle");

    // A new transfer is never taken during the clearing pass.
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |=> state_reg == S_CLEAR || state_reg == S_IDLE)
        else $error("clearing pass left early");

endmodule

### tb/bitmap_frame_allocator_refcount_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_refcount_tb
// Drives allocate, free, reference count and range transfers into the frame
// allocator and checks every result against a local bitmap and count model.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_refcount_tb;

    localparam int FRAMES     = 4096;
    localparam int WORDS      = FRAMES / 32;
    localparam int IDLE_PCT   = 36;
    localparam int DRAIN_WAIT = 160;
    localparam int STALL_MAX  = 30000;

    // Opcode with no operation behind it.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    bfa_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    bfa_pkg::out_item_t out_data;
    logic               cfg_wr_en = 1'b0;
    logic [12:0]        cfg_wr_data = '0;

    // Model state of the allocator.
    logic [31:0] frame_bits [WORDS];
    logic [15:0] frame_refs [FRAMES];
    logic [12:0] used_count;
    logic [12:0] managed;

    bfa_pkg::in_item_t  pending_ops[$];
    bfa_pkg::out_item_t expected_results[$];
    int                 error_count = 0;
    int                 quiet_cycles = 0;
    bit                 no_idle = 1'b0;

    bitmap_frame_allocator_refcount u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic frame_used(int f);
        return frame_bits[f >> 5][f & 31];
    endfunction

    function automatic logic [1:0] release_frame(int f);
        if (f >= managed || f >= FRAMES)
            return bfa_pkg::ST_INVALID;
        if (!frame_used(f))
            return bfa_pkg::ST_DOUBLE;
        frame_bits[f >> 5][f & 31] = 1'b0;
        if (used_count != 0)
            used_count--;
        return bfa_pkg::ST_OK;
    endfunction

    function automatic void count_up();
        if (used_count != bfa_pkg::CNT_MAX)
            used_count++;
    endfunction

    // Applies one operation to the model and queues the result it gives.
    function automatic void apply_op(bfa_pkg::in_item_t op);
        bfa_pkg::out_item_t res;
        int        f;
        int        last;
        int        words;
        bit        found;
        logic      valid_ref;
        f         = op.frame_index;
        res       = '0;
        res.status = bfa_pkg::ST_OK;
        res.result_frame = op.frame_index;
        valid_ref = 1'b1;
        case (op.opcode)
            bfa_pkg::OP_ALLOC:
            begin
                words = managed / 32;
                if (words > WORDS)
                    words = WORDS;
                found = 1'b0;
                for (int w = 0; w < words && !found; w++)
                    for (int b = 0; b < 32 && !found; b++)
                        if (!frame_bits[w][b])
                        begin
                            found = 1'b1;
                            f = w * 32 + b;
                        end
                if (found)
                begin
                    frame_bits[f >> 5][f & 31] = 1'b1;
                    count_up();
                    frame_refs[f] = 16'd1;
                    res.result_frame = f[11:0];
                end
                else
                begin
                    res.result_frame = '0;
                    res.status = bfa_pkg::ST_NOMEM;
                    valid_ref = 1'b0;
                end
            end
            bfa_pkg::OP_FREE:
                res.status = release_frame(f);
            bfa_pkg::OP_REF_INC:
                if (frame_refs[f] != 16'hFFFF)
                    frame_refs[f]++;
            bfa_pkg::OP_REF_DEC:
            begin
                if (frame_refs[f] != 0)
                    frame_refs[f]--;
                if (frame_refs[f] == 0)
                    res.status = release_frame(f);
            end
            bfa_pkg::OP_RELEASE, bfa_pkg::OP_RESERVE:
            begin
                last = f + op.frame_count;
                if (last > FRAMES)
                    last = FRAMES;
                for (int k = f; k < last; k++)
                    if (op.opcode == bfa_pkg::OP_RELEASE)
                        frame_bits[k >> 5][k & 31] = 1'b0;
                    else if (!frame_used(k))
                    begin
                        frame_bits[k >> 5][k & 31] = 1'b1;
                        count_up();
                    end
            end
            default: ;
        endcase
        res.ref_value  = valid_ref ? frame_refs[f] : 16'd0;
        res.used_total = used_count;
        expected_results.push_back(res);
    endfunction

    // Driver: payload holds while stalled, next transfer loaded otherwise.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_op(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_ops.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_ops.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);

    // Monitor: each result transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin
        bfa_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.result_frame !== want.result_frame)
                begin
                    $display("%0t: result_frame expected %0d actual %0d",
                             $time, want.result_frame, out_data.result_frame);
                    error_count++;
                end
                if (out_data.ref_value !== want.ref_value)
                begin
                    $display("%0t: ref_value expected %0d actual %0d",
                             $time, want.ref_value, out_data.ref_value);
                    error_count++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    error_count++;
                end
                if (out_data.used_total !== want.used_total)
                begin
                    $display("%0t: used_total expected %0d actual %0d",
                             $time, want.used_total, out_data.used_total);
                    error_count++;
                end
            end
        end
    end

    // The clearing pass after reset is covered by the stall limit.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_op(logic [2:0] code, int f, int n);
        bfa_pkg::in_item_t op;
        op.opcode      = code;
        op.frame_index = f[11:0];
        op.frame_count = n[12:0];
        pending_ops.push_back(op);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_managed(logic [12:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        managed = value;
    endtask

    // Mostly small frames so allocations, frees and counts interact.
    task automatic add_random(int total);
        int pick;
        int f;
        int n;
        add_op(bfa_pkg::OP_RELEASE, $urandom_range(0, 64), $urandom_range(32, 200));
        for (int i = 0; i < total; i++)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       f = $urandom_range(0, FRAMES - 1);
                1:       f = (managed + $urandom_range(0, 4) > 2) ?
                             (managed + $urandom_range(0, 4) - 2) & 12'hFFF : 0;
                default: f = $urandom_range(0, 159);
            endcase
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(0, 8191);
                1, 2:    n = $urandom_range(0, FRAMES);
                default: n = $urandom_range(0, 40);
            endcase
            if (pick < 30)
                add_op(bfa_pkg::OP_ALLOC, f, n);
            else if (pick < 50)
                add_op(bfa_pkg::OP_FREE, f, n);
            else if (pick < 60)
                add_op(bfa_pkg::OP_REF_INC, f, n);
            else if (pick < 75)
                add_op(bfa_pkg::OP_REF_DEC, f, n);
            else if (pick < 83)
                add_op(bfa_pkg::OP_REF_GET, f, n);
            else if (pick < 91)
                add_op(bfa_pkg::OP_RELEASE, f, n);
            else if (pick < 98)
                add_op(bfa_pkg::OP_RESERVE, f, n);
            else
                add_op(OP_UNUSED, f, n);
        end
    endtask

    initial
    begin
        foreach (frame_bits[w])
            frame_bits[w] = '1;
        foreach (frame_refs[k])
            frame_refs[k] = '0;
        used_count = '0;
        managed    = 13'd4096;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Everything starts used, so the first alloc has nowhere to go.
        add_op(bfa_pkg::OP_ALLOC, 0, 0);
        add_op(bfa_pkg::OP_FREE, 5, 0);
        add_op(bfa_pkg::OP_FREE, 5, 0);
        add_op(bfa_pkg::OP_RELEASE, 0, 64);
        add_op(bfa_pkg::OP_ALLOC, 4095, 8191);
        add_op(bfa_pkg::OP_ALLOC, 0, 0);
        add_op(bfa_pkg::OP_REF_INC, 1, 0);
        add_op(bfa_pkg::OP_REF_GET, 1, 0);
        add_op(bfa_pkg::OP_REF_DEC, 1, 0);
        add_op(bfa_pkg::OP_REF_DEC, 1, 0);
        add_op(bfa_pkg::OP_REF_DEC, 1, 0);
        add_op(bfa_pkg::OP_FREE, 4095, 0);
        add_op(bfa_pkg::OP_RESERVE, 4090, 4096);
        add_op(bfa_pkg::OP_RELEASE, 0, 0);
        add_op(OP_UNUSED, 4095, 8191);
        add_op(bfa_pkg::OP_RESERVE, 0, 8191);
        wait_idle();

        // A partial last word is never scanned.
        write_managed(13'd100);
        add_op(bfa_pkg::OP_RELEASE, 90, 20);
        add_op(bfa_pkg::OP_ALLOC, 0, 0);
        add_op(bfa_pkg::OP_FREE, 100, 0);
        add_op(bfa_pkg::OP_FREE, 99, 0);
        add_op(bfa_pkg::OP_FREE, 96, 0);
        add_random(130);
        wait_idle();

        write_managed(13'd0);
        add_op(bfa_pkg::OP_ALLOC, 0, 0);
        add_op(bfa_pkg::OP_FREE, 0, 0);
        add_random(90);
        wait_idle();

        // Release does not lower the used count, so repeated reserves
        // drive it into saturation.
        write_managed(13'd8191);
        for (int r = 0; r < 3; r++)
        begin
            add_op(bfa_pkg::OP_RELEASE, 0, 4096);
            add_op(bfa_pkg::OP_RESERVE, 0, 4096);
        end
        add_random(130);
        wait_idle();

        write_managed(13'd4096);
        no_idle = 1'b1;
        add_op(bfa_pkg::OP_RELEASE, 0, 32);
        add_op(bfa_pkg::OP_ALLOC, 0, 0);
        for (int r = 0; r < 8; r++)
            add_op(bfa_pkg::OP_REF_INC, 0, 0);
        add_op(bfa_pkg::OP_REF_GET, 0, 0);
        add_op(bfa_pkg::OP_REF_DEC, 0, 0);
        add_random(130);
        wait_idle();
        no_idle = 1'b0;

        write_managed(13'd64);
        add_random(130);
        wait_idle();

        write_managed(13'd4000);
        add_random(90);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
